>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/lic_pkg.sv
package lic_pkg;

  // Capacity register value after reset
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/lru_id_cache_policy.sv
// Channel   Handshake                 Payload
// config    cfg_we                    cfg_wdata (capacity)
// request   in_valid / in_stall       func, ident
// result    out_valid / out_stall     hit, slot, evicted, victim, occupancy
//
// An access reads the tag RAM one slot per cycle through its single registered
// read port, then passes through a drain and an apply state. A clear goes
// straight to apply. in_stall is high from acceptance until the return to idle.
// Synchronous reset empties the store and sets capacity to 16.
// A pending result in the output register stalls only the apply cycle.
module lru_id_cache_policy #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [3:0]  slot,
  output logic        evicted,
  output logic [15:0] victim,
  output logic [4:0]  occupancy
);

  import lic_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lic_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .func    (func),
    .stat    (stat),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  lic_dp #(
    .ENTRIES(ENTRIES),
    .ID_BITS(ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .func     (func),
    .ident    (ident),
    .cmd      (cmd),
    .stat     (stat),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .hit      (hit),
    .slot     (slot),
    .evicted  (evicted),
    .victim   (victim),
    .occupancy(occupancy)
  );

endmodule

>>> rtl/lic_ram.sv
module lic_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lic_ctrl.sv
module lic_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          func,
  input  lic_pkg::stat_t stat,
  output lic_pkg::cmd_t  cmd,
  output logic          in_stall
);

  import lic_pkg::*;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = func ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_APPLY: begin
        cmd.apply = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/lic_dp.sv
module lic_dp #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_wdata,
  input  logic           func,
  input  logic [15:0]    ident,
  input  lic_pkg::cmd_t  cmd,
  output lic_pkg::stat_t stat,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           hit,
  output logic [3:0]     slot,
  output logic           evicted,
  output logic [15:0]    victim,
  output logic [4:0]     occupancy
);

  import lic_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IN_W  = (ID_BITS < 16) ? ID_BITS : 16;

  logic [4:0]         capacity;
  logic [CNT_W-1:0]   eff_cap;
  logic [ID_BITS-1:0] id_reg;
  logic               op_clear;
  logic [IDX_W-1:0]   addr;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [ID_BITS-1:0] rd_tag;
  logic               found;
  logic [IDX_W-1:0]   fidx;
  logic [IDX_W-1:0]   frank;
  logic               have_empty;
  logic [IDX_W-1:0]   eidx;
  logic [IDX_W-1:0]   oidx;
  logic [ID_BITS-1:0] vtag;
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   rank [ENTRIES];
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   count_m1;
  logic               evict;
  logic [IDX_W-1:0]   target;
  logic [CNT_W-1:0]   count_next;
  logic               ram_we;
  logic               rd_valid_bit;
  logic [IDX_W-1:0]   rd_rank;

  // Clamp capacity to the store size, at least one
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign count_m1     = IDX_W'(count - CNT_W'(1));
  assign rd_valid_bit = valid[rd_idx];
  assign rd_rank      = rank[rd_idx];

  // Miss handling: evict the oldest entry when full, else take the lowest free slot
  assign evict      = (count >= eff_cap) && (count != '0);
  assign target     = evict ? oidx : eidx;
  assign count_next = op_clear ? '0 : ((found || evict) ? count : count + CNT_W'(1));
  assign ram_we     = cmd.apply && !op_clear && !found;

  assign stat.scan_last = (32'(addr) == ENTRIES - 1);
  assign stat.out_busy  = out_valid && out_stall;

  lic_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(ENTRIES)
  ) u_tags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(target),
    .wdata(id_reg),
    .re   (cmd.scan),
    .raddr(addr),
    .rdata(rd_tag)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Latch request and step the scan address
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
    end
    if (cmd.start) begin
      id_reg   <= ID_BITS'(ident[IN_W-1:0]);
      op_clear <= func;
      addr     <= '0;
    end else if (cmd.scan) begin
      addr <= addr + IDX_W'(1);
    end
    rd_idx <= addr;
  end

  // Collect hit, free slot and oldest entry as tags stream out of the RAM
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found      <= 1'b0;
      have_empty <= 1'b0;
      fidx       <= '0;
      frank      <= '0;
      eidx       <= '0;
      oidx       <= '0;
      vtag       <= '0;
    end else if (rd_vld) begin
      if (rd_valid_bit && rd_tag == id_reg && !found) begin
        found <= 1'b1;
        fidx  <= rd_idx;
        frank <= rd_rank;
      end
      if (!rd_valid_bit && !have_empty) begin
        have_empty <= 1'b1;
        eidx       <= rd_idx;
      end
      if (rd_valid_bit && rd_rank == count_m1) begin
        oidx <= rd_idx;
        vtag <= rd_tag;
      end
    end
  end

  // Update valid bits, ranks and count on apply
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        rank[k] <= '0;
      end
    end else if (cmd.apply) begin
      count <= count_next;
      if (op_clear) begin
        valid <= '0;
        for (int k = 0; k < ENTRIES; k++) begin
          rank[k] <= '0;
        end
      end else if (found) begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (valid[k] && IDX_W'(k) != fidx && rank[k] < frank) begin
            rank[k] <= rank[k] + IDX_W'(1);
          end
        end
        rank[fidx] <= '0;
      end else begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (valid[k] && IDX_W'(k) != target) begin
            rank[k] <= rank[k] + IDX_W'(1);
          end
        end
        rank[target]  <= '0;
        valid[target] <= 1'b1;
      end
    end
  end

  // Output register: load on apply, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.apply) begin
      occupancy <= 5'(count_next);
      if (op_clear) begin
        hit     <= 1'b0;
        slot    <= '0;
        evicted <= 1'b0;
        victim  <= '0;
      end else if (found) begin
        hit     <= 1'b1;
        slot    <= 4'(fidx);
        evicted <= 1'b0;
        victim  <= '0;
      end else begin
        hit     <= 1'b0;
        slot    <= 4'(target);
        evicted <= evict;
        victim  <= evict ? 16'(vtag) : 16'd0;
      end
    end
  end

endmodule

>>> rtl/lic_checker.sv
`include "assert_macros.svh"

module lic_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic        evicted,
  input logic [15:0] victim,
  input logic [4:0]  occupancy
);

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  // Stay busy right after taking a request
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // An eviction is never a hit and leaves the store non-empty
  `ASSERT_NOW(a_evict_miss, clk, rst, out_valid && evicted, !hit && occupancy != 5'd0)
  // A hit reports no victim
  `ASSERT_NOW(a_hit_clean, clk, rst, out_valid && hit,
              !evicted && victim == 16'd0 && occupancy != 5'd0)

endmodule

bind lru_id_cache_policy lic_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .hit      (hit),
  .evicted  (evicted),
  .victim   (victim),
  .occupancy(occupancy)
);

>>> bench/lru_id_cache_policy_tb.sv
module lru_id_cache_policy_tb;

  localparam int ENTRIES      = 16;
  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POOL_SIZE    = 24;

  // Request commands
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evicted;
    logic [15:0] victim;
    logic [4:0]  occupancy;
  } cache_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [15:0] ident;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic [3:0]  slot;
  logic        evicted;
  logic [15:0] victim;
  logic [4:0]  occupancy;

  // Shadow copy of the cache state
  logic [15:0] tag_mem [ENTRIES];
  bit          tag_live [ENTRIES];
  int          age [ENTRIES];
  int          live_count;
  logic [4:0]  cap_reg;

  cache_result_t pending_results[$];
  logic [15:0]   id_pool [POOL_SIZE];

  int err_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  lru_id_cache_policy #(
    .ENTRIES(ENTRIES),
    .ID_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .ident(ident),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .slot(slot),
    .evicted(evicted),
    .victim(victim),
    .occupancy(occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    err_count++;
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {11'd0, occupancy}, 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit)
          report_mismatch("hit", 16'(hit), 16'(want.hit));
        if (slot !== want.slot)
          report_mismatch("slot", 16'(slot), 16'(want.slot));
        if (evicted !== want.evicted)
          report_mismatch("evicted", 16'(evicted), 16'(want.evicted));
        if (victim !== want.victim)
          report_mismatch("victim", victim, want.victim);
        if (occupancy !== want.occupancy)
          report_mismatch("occupancy", 16'(occupancy), 16'(want.occupancy));
      end
    end
  end

  // Predict the result of one request and update the shadow state
  task automatic predict_lru(input logic f, input logic [15:0] id);
    cache_result_t r;
    int found;
    int target;
    int oldest;
    int eff_cap;
    r = '0;
    if (f == FUNC_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_live[i] = 0;
        age[i] = 0;
      end
      live_count = 0;
    end else begin
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && tag_live[i] && tag_mem[i] == id) found = i;
      if (found >= 0) begin
        // Hit: promote to most recent, age the ones that were newer
        r.hit = 1'b1;
        r.slot = found[3:0];
        for (int i = 0; i < ENTRIES; i++)
          if (tag_live[i] && i != found && age[i] < age[found]) age[i]++;
        age[found] = 0;
      end else begin
        target = -1;
        eff_cap = (cap_reg < 1) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
        // Full: evict the least recent entry
        if (live_count >= eff_cap && live_count > 0) begin
          oldest = 0;
          for (int i = 0; i < ENTRIES; i++)
            if (tag_live[i] && (target < 0 || age[i] > oldest)) begin
              target = i;
              oldest = age[i];
            end
          if (target >= 0) begin
            r.evicted = 1'b1;
            r.victim = tag_mem[target];
            tag_live[target] = 0;
            live_count--;
          end
        end
        if (target < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (target < 0 && !tag_live[i]) target = i;
        if (target >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (tag_live[i] && i != target) age[i]++;
          tag_mem[target] = id;
          tag_live[target] = 1;
          age[target] = 0;
          live_count++;
          r.slot = target[3:0];
        end
      end
    end
    r.occupancy = live_count[4:0];
    pending_results.push_back(r);
  endtask

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic f, input logic [15:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      func <= logic'($urandom_range(0, 1));
      ident <= 16'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    ident <= id;
    do @(posedge clk); while (in_stall);
    predict_lru(f, id);
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    wait_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cap_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 5'($urandom);
  endtask

  // Mostly reuse a small pool so hits and evictions are frequent
  task automatic run_random(input int count);
    int reach;
    logic [15:0] id;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    reach = (cap_reg < 1) ? 3 : ((cap_reg > ENTRIES) ? ENTRIES + 3 : int'(cap_reg) + 3);
    if (reach > POOL_SIZE - 1) reach = POOL_SIZE - 1;
    for (int n = 0; n < count; n++) begin
      id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, reach)]
                                        : 16'($urandom);
      if ($urandom_range(0, 99) < 3) send_request(FUNC_CLEAR, 16'($urandom));
      else send_request(FUNC_ACCESS, id);
    end
  endtask

  task automatic test_directed_access();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(FUNC_CLEAR, 16'h0000);
    send_request(FUNC_ACCESS, 16'h0000);
    send_request(FUNC_ACCESS, 16'hFFFF);
    send_request(FUNC_ACCESS, 16'h0000);
    send_request(FUNC_ACCESS, 16'h5A5A);
    send_request(FUNC_ACCESS, 16'hFFFF);
    send_request(FUNC_CLEAR, 16'hFFFF);
    send_request(FUNC_ACCESS, 16'hFFFF);
  endtask

  task automatic test_capacity_limits();
    // Zero acts as one
    write_capacity(5'd0);
    send_request(FUNC_ACCESS, 16'h1111);
    send_request(FUNC_ACCESS, 16'h2222);
    send_request(FUNC_ACCESS, 16'h2222);
    send_request(FUNC_CLEAR, 16'h0000);
    // Above the store acts as the store size
    write_capacity(5'd31);
    send_request(FUNC_ACCESS, 16'h0001);
    send_request(FUNC_ACCESS, 16'h0002);
    send_request(FUNC_CLEAR, 16'h0000);
    // Eviction of the least recent entry
    write_capacity(5'd2);
    send_request(FUNC_ACCESS, 16'h8000);
    send_request(FUNC_ACCESS, 16'h4000);
    send_request(FUNC_ACCESS, 16'h8000);
    send_request(FUNC_ACCESS, 16'h0001);
    // Lowered while full: occupancy holds
    write_capacity(5'd1);
    send_request(FUNC_ACCESS, 16'h0002);
    send_request(FUNC_ACCESS, 16'h0003);
    send_request(FUNC_CLEAR, 16'h0000);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [4:0] cap_a, input logic [4:0] cap_b);
    write_capacity(cap_a);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    run_random(220);
    write_capacity(cap_b);
    run_random(220);
  endtask

  task automatic test_backpressure();
    write_capacity(5'd3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    run_random(40);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 5'd0;
    in_valid = 1'b0;
    func = FUNC_ACCESS;
    ident = 16'd0;
    out_stall = 1'b0;
    err_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    live_count = 0;
    cap_reg = lic_pkg::CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_mem[i] = '0;
      tag_live[i] = 0;
      age[i] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_access();
    test_capacity_limits();
    test_random_phase(0, 0, 5'd16, 5'd4);
    test_random_phase(63, 0, 5'd1, 5'd31);
    test_random_phase(0, 63, 5'd0, 5'($urandom_range(2, 15)));
    test_random_phase(32, 32, 5'd8, 5'd16);
    test_backpressure();

    wait_drain();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
